>>> hw/rtl/clc_pkg.sv
// Shared types and constants of the code lock controller.
// Used by the register bank, the evaluation core, the top level and the testbench.
`timescale 1ns / 1ps

package clc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_KEY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAL_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAL_HIGH   = 3'd5;

	localparam logic [1:0] ACT_KEY   = 2'd0;
	localparam logic [1:0] ACT_DIAL  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [2:0] BEEPS_NONE  = 3'd0;
	localparam logic [2:0] BEEPS_SHORT = 3'd2;
	localparam logic [2:0] BEEPS_LONG  = 3'd6;

	localparam logic [3:0] TRIES_RESET = 4'd3;

	typedef enum logic [3:0] {
		ST_IGNORED   = 4'd0,
		ST_DIGIT     = 4'd1,
		ST_DISCARDED = 4'd2,
		ST_WRONG     = 4'd3,
		ST_ALARM     = 4'd4,
		ST_CORRECT   = 4'd5,
		ST_CLOSED    = 4'd6,
		ST_DIAL1_OK  = 4'd7,
		ST_OPENED    = 4'd8,
		ST_CLEARED   = 4'd9,
		ST_NO_CHANGE = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		DIAL_IDLE   = 3'b001,
		DIAL_FIRST  = 3'b010,
		DIAL_SECOND = 3'b100
	} dial_t;

	typedef struct packed {
		logic [15:0] open_code;
		logic [15:0] close_code;
		logic [3:0]  confirm_key;
		logic [3:0]  max_tries;
		logic [9:0]  dial_low;
		logic [9:0]  dial_high;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		open_code:   16'd5528,
		close_code:  16'hFFFF,
		confirm_key: 4'd10,
		max_tries:   4'd3,
		dial_low:    10'd490,
		dial_high:   10'd519
	};

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] key_code;
		logic [9:0] dial_sample;
		logic       button_pressed;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic       door_open;
		logic [2:0] beeps;
		logic       dial_channel;
		logic       alarm_on;
		logic [3:0] tries_remaining;
	} result_t;

endpackage

>>> hw/rtl/clc_if.sv
// Valid/ready channels of the code lock controller: input word and result word.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface clc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [3:0] key_code;
	logic [9:0] dial_sample;
	logic       button_pressed;

	modport source (output valid, action, key_code, dial_sample, button_pressed, input ready);
	modport sink   (input valid, action, key_code, dial_sample, button_pressed, output ready);
endinterface

interface clc_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic       door_open;
	logic [2:0] beeps;
	logic       dial_channel;
	logic       alarm_on;
	logic [3:0] tries_remaining;

	modport source (output valid, status, door_open, beeps, dial_channel, alarm_on,
		tries_remaining, input ready);
	modport sink   (input valid, status, door_open, beeps, dial_channel, alarm_on,
		tries_remaining, output ready);
endinterface

>>> hw/rtl/code_lock_controller_top.sv
// Channel   Dir  Contents
// items     in   action, key_code, dial_sample, button_pressed
// results   out  status, door_open, beeps, dial_channel, alarm_on, tries_remaining
// cfg_*     in   register write: enable, index, data
//
// One word per cycle while the result side is ready; a result is valid once its word has
// passed the input register and been loaded into the result register, which waits while stalled.
// Lock state updates as a word leaves the input register, so the next word sees it.
// Reset restores the register defaults and the closed, idle lock state.
// A stalled result holds in the result register while the input register takes one more word.
// Depends on clc_pkg, clc_if, clc_cfg_regs and clc_core.
`timescale 1ns / 1ps

module code_lock_controller_top #(
	parameter int CODE_KEYS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [clc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	clc_item_if.sink                       items,
	clc_result_if.source                   results
);
	import clc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance     = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || advance;

	clc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	clc_core #(
		.CODE_KEYS (CODE_KEYS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (items.ready) valid_s1 <= items.valid;
			if (!valid_s2 || results.ready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= '{
				action:         items.action,
				key_code:       items.key_code,
				dial_sample:    items.dial_sample,
				button_pressed: items.button_pressed
			};
		end
		if (advance) res_s2 <= res_next;
	end

	assign results.valid           = valid_s2;
	assign results.status          = res_s2.status;
	assign results.door_open       = res_s2.door_open;
	assign results.beeps           = res_s2.beeps;
	assign results.dial_channel    = res_s2.dial_channel;
	assign results.alarm_on        = res_s2.alarm_on;
	assign results.tries_remaining = res_s2.tries_remaining;

`ifndef NO_ASSERTIONS
	a_alarm_tries: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == ST_ALARM
		|-> results.alarm_on && results.tries_remaining == 4'd0)
		else $error("alarm word without alarm flag or with tries left");

	a_opened_door: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == ST_OPENED
		|-> results.door_open && !results.dial_channel)
		else $error("opened word with door closed or dial still active");

	a_alarm_no_dial: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.alarm_on |-> !results.dial_channel)
		else $error("dial stage active during alarm");

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("evaluated word lost before result register");
`endif

endmodule

>>> hw/rtl/clc_cfg_regs.sv
// Configuration register bank of the code lock controller.
// Depends on clc_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module clc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [clc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output clc_pkg::cfg_t                  cfg
);
	import clc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPEN_CODE:   cfg_q.open_code   <= cfg_wdata;
				CFG_CLOSE_CODE:  cfg_q.close_code  <= cfg_wdata;
				CFG_CONFIRM_KEY: cfg_q.confirm_key <= cfg_wdata[3:0];
				CFG_MAX_TRIES:   cfg_q.max_tries   <= cfg_wdata[3:0];
				CFG_DIAL_LOW:    cfg_q.dial_low    <= cfg_wdata[9:0];
				CFG_DIAL_HIGH:   cfg_q.dial_high   <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/clc_core.sv
// Lock state and single-pass evaluation of one input word.
// Depends on clc_pkg; state advances when step is high.
`timescale 1ns / 1ps

module clc_core #(
	parameter int CODE_KEYS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  clc_pkg::cfg_t    cfg,
	input  clc_pkg::item_t   item,
	output clc_pkg::result_t res
);
	import clc_pkg::*;

	localparam int KEY_CNT_W = $clog2(CODE_KEYS + 1);
	localparam int CODE_BITS = (4 * CODE_KEYS >= 16) ? 16 : 4 * CODE_KEYS;
	localparam logic [KEY_CNT_W-1:0] KEYS_FULL = KEY_CNT_W'(CODE_KEYS);

	logic [15:0]          entry_q, entry_d;
	logic [KEY_CNT_W-1:0] keys_q, keys_d;
	logic                 door_q, door_d;
	logic [3:0]           tries_q, tries_d;
	logic                 alarm_q, alarm_d;
	dial_t                dial_q, dial_d;

	status_t    status;
	logic [2:0] beeps;
	logic       hit;
	logic       is_close, is_open;
	logic [3:0] tries_dec;

	assign is_close  = entry_q[CODE_BITS-1:0] == cfg.close_code[CODE_BITS-1:0];
	assign is_open   = entry_q[CODE_BITS-1:0] == cfg.open_code[CODE_BITS-1:0];
	assign tries_dec = (tries_q == 4'd0) ? 4'd0 : tries_q - 4'd1;
	assign hit = item.button_pressed && (item.dial_sample >= cfg.dial_low)
		&& (item.dial_sample <= cfg.dial_high);

	always_comb begin
		entry_d = entry_q;
		keys_d  = keys_q;
		door_d  = door_q;
		tries_d = tries_q;
		alarm_d = alarm_q;
		dial_d  = dial_q;
		status  = ST_IGNORED;
		beeps   = BEEPS_NONE;
		case (item.action)
			ACT_KEY: begin
				if (!alarm_q && dial_q == DIAL_IDLE) begin
					if (keys_q < KEYS_FULL) begin
						entry_d = {entry_q[11:0], item.key_code};
						keys_d  = keys_q + KEY_CNT_W'(1);
						status  = ST_DIGIT;
					end else begin
						// confirm slot: the entry is always dropped; anything but the confirm key discards it unchecked
						entry_d = '0;
						keys_d  = '0;
						if (item.key_code != cfg.confirm_key) begin
							status = ST_DISCARDED;
						end else if (is_close && door_q) begin
							door_d = 1'b0;
							dial_d = DIAL_IDLE;
							beeps  = BEEPS_SHORT;
							status = ST_CLOSED;
						end else if (!is_open) begin
							beeps   = BEEPS_LONG;
							tries_d = tries_dec;
							if (tries_dec == 4'd0) begin
								alarm_d = 1'b1;
								status  = ST_ALARM;
							end else begin
								status = ST_WRONG;
							end
						end else begin
							beeps  = BEEPS_SHORT;
							dial_d = DIAL_FIRST;
							status = ST_CORRECT;
						end
					end
				end
			end
			ACT_DIAL: begin
				if (!alarm_q && dial_q != DIAL_IDLE) begin
					if (!hit) begin
						status = ST_NO_CHANGE;
					end else if (dial_q == DIAL_FIRST) begin
						dial_d = DIAL_SECOND;
						status = ST_DIAL1_OK;
					end else begin
						dial_d = DIAL_IDLE;
						door_d = 1'b1;
						status = ST_OPENED;
					end
				end
			end
			ACT_CLEAR: begin
				if (alarm_q) begin
					alarm_d = 1'b0;
					tries_d = cfg.max_tries;
					status  = ST_CLEARED;
				end else begin
					status = ST_NO_CHANGE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			keys_q  <= '0;
			door_q  <= 1'b0;
			tries_q <= TRIES_RESET;
			alarm_q <= 1'b0;
			dial_q  <= DIAL_IDLE;
		end else if (step) begin
			entry_q <= entry_d;
			keys_q  <= keys_d;
			door_q  <= door_d;
			tries_q <= tries_d;
			alarm_q <= alarm_d;
			dial_q  <= dial_d;
		end
	end

	assign res = '{
		status:          status,
		door_open:       door_d,
		beeps:           beeps,
		dial_channel:    dial_d == DIAL_SECOND,
		alarm_on:        alarm_d,
		tries_remaining: tries_d
	};

endmodule

>>> dv/testbench.sv
// Self-checking bench for code_lock_controller_top: directed lock scenarios, register
// sweeps and random key/dial/clear traffic checked against an in-bench lock model.
// Depends on clc_pkg, clc_if and the code_lock_controller_top RTL.
`timescale 1ns / 1ps

module testbench;
	import clc_pkg::*;

	localparam int CODE_KEYS = 4;
	localparam logic [15:0] CODE_MASK =
		(4 * CODE_KEYS >= 16) ? 16'hFFFF : 16'((32'd1 << (4 * CODE_KEYS)) - 1);
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	clc_item_if items_ch ();
	clc_result_if results_ch ();

	code_lock_controller_top #(.CODE_KEYS(CODE_KEYS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.items     (items_ch),
		.results   (results_ch)
	);

	// lock model state
	cfg_t        lock_cfg;
	logic [15:0] entry_acc;
	int          keys_held;
	logic        door_is_open;
	logic [3:0]  tries_budget;
	logic        alarm_active;
	dial_t       dial_phase;
	result_t     replies_due[$];
	item_t       seen_word;

	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL code_lock_controller_top");
		$finish;
	end

	function automatic result_t lock_reaction(input item_t w);
		result_t r;
		logic [15:0] e;
		r = '0;
		r.status = ST_IGNORED;
		r.beeps = BEEPS_NONE;
		case (w.action)
		ACT_KEY: begin
			if (!alarm_active && dial_phase == DIAL_IDLE) begin
				if (keys_held < CODE_KEYS) begin
					entry_acc = {entry_acc[11:0], w.key_code};
					keys_held++;
					r.status = ST_DIGIT;
				end else begin
					e = entry_acc & CODE_MASK;
					if (w.key_code != lock_cfg.confirm_key) begin
						r.status = ST_DISCARDED;
					end else if (e == (lock_cfg.close_code & CODE_MASK) && door_is_open) begin
						door_is_open = 1'b0;
						dial_phase = DIAL_IDLE;
						r.beeps = BEEPS_SHORT;
						r.status = ST_CLOSED;
					end else if (e != (lock_cfg.open_code & CODE_MASK)) begin
						r.beeps = BEEPS_LONG;
						if (tries_budget != 4'd0) tries_budget = tries_budget - 4'd1;
						if (tries_budget == 4'd0) begin
							alarm_active = 1'b1;
							r.status = ST_ALARM;
						end else begin
							r.status = ST_WRONG;
						end
					end else begin
						r.beeps = BEEPS_SHORT;
						dial_phase = DIAL_FIRST;
						r.status = ST_CORRECT;
					end
					entry_acc = '0;
					keys_held = 0;
				end
			end
		end
		ACT_DIAL: begin
			if (!alarm_active && dial_phase != DIAL_IDLE) begin
				if (!(w.dial_sample >= lock_cfg.dial_low && w.dial_sample <= lock_cfg.dial_high
						&& w.button_pressed)) begin
					r.status = ST_NO_CHANGE;
				end else if (dial_phase == DIAL_FIRST) begin
					dial_phase = DIAL_SECOND;
					r.status = ST_DIAL1_OK;
				end else begin
					dial_phase = DIAL_IDLE;
					door_is_open = 1'b1;
					r.status = ST_OPENED;
				end
			end
		end
		ACT_CLEAR: begin
			if (alarm_active) begin
				alarm_active = 1'b0;
				tries_budget = lock_cfg.max_tries;
				r.status = ST_CLEARED;
			end else begin
				r.status = ST_NO_CHANGE;
			end
		end
		default: ;
		endcase
		r.door_open = door_is_open;
		r.dial_channel = (dial_phase == DIAL_SECOND);
		r.alarm_on = alarm_active;
		r.tries_remaining = tries_budget;
		return r;
	endfunction

	// register writes and accepted words, in edge order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_cfg = CFG_RESET;
			entry_acc = '0;
			keys_held = 0;
			door_is_open = 1'b0;
			tries_budget = TRIES_RESET;
			alarm_active = 1'b0;
			dial_phase = DIAL_IDLE;
			replies_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_OPEN_CODE:   lock_cfg.open_code = cfg_wdata;
				CFG_CLOSE_CODE:  lock_cfg.close_code = cfg_wdata;
				CFG_CONFIRM_KEY: lock_cfg.confirm_key = cfg_wdata[3:0];
				CFG_MAX_TRIES:   lock_cfg.max_tries = cfg_wdata[3:0];
				CFG_DIAL_LOW:    lock_cfg.dial_low = cfg_wdata[9:0];
				CFG_DIAL_HIGH:   lock_cfg.dial_high = cfg_wdata[9:0];
				default: ;
				endcase
			end
			if (items_ch.valid && items_ch.ready) begin
				seen_word.action = items_ch.action;
				seen_word.key_code = items_ch.key_code;
				seen_word.dial_sample = items_ch.dial_sample;
				seen_word.button_pressed = items_ch.button_pressed;
				replies_due.push_back(lock_reaction(seen_word));
			end
		end
	end

	function automatic void compare_field(input string name, input logic [3:0] want,
			input logic [3:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (replies_due.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result word with none expected, got status %0d",
					$time, results_ch.status);
			end else begin
				want = replies_due.pop_front();
				compare_field("status", want.status, results_ch.status);
				compare_field("door_open", 4'(want.door_open), 4'(results_ch.door_open));
				compare_field("beeps", 4'(want.beeps), 4'(results_ch.beeps));
				compare_field("dial_channel", 4'(want.dial_channel),
					4'(results_ch.dial_channel));
				compare_field("alarm_on", 4'(want.alarm_on), 4'(results_ch.alarm_on));
				compare_field("tries_remaining", want.tries_remaining,
					results_ch.tries_remaining);
			end
		end
	end

	// result-side ready; a requested hold-off takes priority over random stalls
	initial begin
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// valid is left high after acceptance; the next call either replaces the word or drops it
	task automatic send_event(input logic [1:0] action, input logic [3:0] key,
			input logic [9:0] sample, input logic button);
		while ($urandom_range(99) < sender_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.action <= action;
		items_ch.key_code <= key;
		items_ch.dial_sample <= sample;
		items_ch.button_pressed <= button;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
	endtask

	task automatic send_key(input logic [3:0] key);
		send_event(ACT_KEY, key, 10'($urandom), 1'($urandom));
	endtask

	task automatic send_dial(input logic [9:0] sample, input logic button);
		send_event(ACT_DIAL, 4'($urandom), sample, button);
	endtask

	task automatic send_clear();
		send_event(ACT_CLEAR, 4'($urandom), 10'($urandom), 1'($urandom));
	endtask

	task automatic enter_code(input logic [31:0] code, input logic [3:0] confirm);
		for (int k = CODE_KEYS - 1; k >= 0; k--) send_key(code[4*k +: 4]);
		send_key(confirm);
	endtask

	task automatic settle();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [15:0] open_c, input logic [15:0] close_c,
			input logic [3:0] confirm, input logic [3:0] tries, input logic [9:0] low,
			input logic [9:0] high);
		write_reg(CFG_OPEN_CODE, open_c);
		write_reg(CFG_CLOSE_CODE, close_c);
		write_reg(CFG_CONFIRM_KEY, 16'(confirm));
		write_reg(CFG_MAX_TRIES, 16'(tries));
		write_reg(CFG_DIAL_LOW, 16'(low));
		write_reg(CFG_DIAL_HIGH, 16'(high));
	endtask

	function automatic logic [9:0] dial_guess();
		if (lock_cfg.dial_low <= lock_cfg.dial_high && $urandom_range(99) < 70)
			return 10'($urandom_range(lock_cfg.dial_high, lock_cfg.dial_low));
		return 10'($urandom);
	endfunction

	task automatic test_idle_events();
		send_event(ACT_UNUSED, 4'($urandom), 10'($urandom), 1'($urandom));
		send_dial(10'd500, 1'b1);
		send_clear();
		enter_code(32'h1598, 4'd3);
		settle();
	endtask

	task automatic test_wrong_until_alarm();
		enter_code(32'h0000, lock_cfg.confirm_key);
		// close code with the door shut counts as a wrong entry
		enter_code(32'hFFFF, lock_cfg.confirm_key);
		enter_code(32'h1234, lock_cfg.confirm_key);
		send_key(4'd1);
		send_dial(10'd500, 1'b1);
		send_clear();
		settle();
	endtask

	task automatic test_open_and_close();
		enter_code(32'h1598, lock_cfg.confirm_key);
		send_key(4'd7);
		send_dial(10'd1023, 1'b1);
		send_dial(10'd490, 1'b0);
		send_dial(10'd489, 1'b1);
		send_dial(10'd490, 1'b1);
		send_dial(10'd520, 1'b1);
		send_dial(10'd519, 1'b1);
		// open code on an open door restarts the dial check
		enter_code(32'h1598, lock_cfg.confirm_key);
		send_dial(10'd500, 1'b1);
		send_dial(10'd500, 1'b1);
		enter_code(32'hFFFF, lock_cfg.confirm_key);
		settle();
	endtask

	task automatic test_register_extremes();
		set_registers(16'h0000, 16'h0000, 4'd15, 4'd0, 10'd1023, 10'd0);
		enter_code(32'h0000, 4'd15);
		// inverted window: nothing is on target
		send_dial(10'd0, 1'b1);
		send_dial(10'd1023, 1'b1);
		settle();
		write_reg(CFG_DIAL_LOW, 16'd0);
		write_reg(CFG_DIAL_HIGH, 16'd1023);
		send_dial(10'd0, 1'b1);
		send_dial(10'd1023, 1'b1);
		enter_code(32'h0000, 4'd15);
		for (int n = 0; n < 3; n++) enter_code(32'hFFFF, 4'd15);
		send_clear();
		// zero tries left: the next wrong entry alarms at once
		enter_code(32'h8421, 4'd15);
		send_clear();
		settle();
	endtask

	task automatic random_traffic(input int count);
		int sent;
		int roll;
		int dials;
		logic [31:0] code;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				roll = $urandom_range(99);
				if (roll < 45) code = 32'(lock_cfg.open_code);
				else if (roll < 65) code = 32'(lock_cfg.close_code);
				else code = $urandom;
				enter_code(code, ($urandom_range(99) < 88) ? lock_cfg.confirm_key
					: 4'($urandom));
				sent += CODE_KEYS + 1;
				if (code[15:0] == lock_cfg.open_code) begin
					dials = $urandom_range(6);
					repeat (dials) send_dial(dial_guess(), $urandom_range(99) < 85);
					sent += dials;
				end
			end else if (roll < 67) begin
				send_clear();
				sent++;
			end else if (roll < 77) begin
				send_dial(dial_guess(), 1'($urandom));
				sent++;
			end else begin
				send_event(2'($urandom), 4'($urandom), 10'($urandom), 1'($urandom));
				sent++;
			end
		end
		settle();
	endtask

	task automatic test_backpressure();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = 300;
		random_traffic(40);
	endtask

	task automatic test_random_phases();
		logic [9:0] low;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		set_registers(16'd5528, 16'hFFFF, 4'd10, 4'd3, 10'd490, 10'd519);
		random_traffic(400);

		low = 10'($urandom);
		set_registers(16'($urandom), 16'($urandom), 4'($urandom), 4'($urandom_range(15, 1)),
			low, (int'(low) + 60 > 1023) ? 10'd1023 : low + 10'($urandom_range(60)));
		sender_idle_pct = 73;
		random_traffic(400);

		sender_idle_pct = 0;
		receiver_stall_pct = 73;
		set_registers(16'($urandom), 16'($urandom), 4'd15, 4'd15, 10'd0, 10'd1023);
		random_traffic(400);

		low = 10'($urandom);
		sender_idle_pct = 9;
		receiver_stall_pct = 9;
		set_registers(16'($urandom), 16'($urandom), 4'd0, 4'd1, low, low);
		random_traffic(400);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		items_ch.valid <= 1'b0;
		items_ch.action <= ACT_KEY;
		items_ch.key_code <= '0;
		items_ch.dial_sample <= '0;
		items_ch.button_pressed <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_events();
		test_wrong_until_alarm();
		test_open_and_close();
		test_register_extremes();
		write_reg(CFG_MAX_TRIES, 16'd3);
		test_backpressure();
		test_random_phases();

		if (mismatch_count == 0)
			$display("PASS code_lock_controller_top");
		else
			$display("FAIL code_lock_controller_top");
		$finish;
	end

endmodule
